// File: hdl/can_frame_to_udp_packet_framer_defines.svh
// Assertion macros shared by the framer's checking code.
`ifndef CAN_FRAME_TO_UDP_PACKET_FRAMER_DEFINES_SVH
`define CAN_FRAME_TO_UDP_PACKET_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define CFUDP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfudp check failed");
`define CFUDP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfudp check failed");
`else
`define CFUDP_ASSERT_IMP(label, clk, rst, ante, cons)
`define CFUDP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/cfudp_pkg.sv
// Types and constants of the CAN frame to packet byte framer.
package cfudp_pkg;

  localparam logic [7:0] FORMAT_VERSION = 8'd2;
  localparam logic [7:0] OPCODE_DATA    = 8'd0;
  localparam int         MAX_DATA_BYTES = 8;

  // One frame as classified by the front end
  typedef struct packed {
    logic        hdr;
    logic [7:0]  seq;
    logic [15:0] count;
    logic [31:0] id_word;
    logic [3:0]  len;
    logic [63:0] data;
  } cfudp_job_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } cfudp_qstat_t;

endpackage

// File: hdl/cfudp_frame_if.sv
// Handshake channel carrying one CAN frame per item.
interface cfudp_frame_if;
  logic        valid;
  logic        ready;
  logic        starts_packet;
  logic [15:0] frames_in_packet;
  logic [28:0] frame_identifier;
  logic        is_extended;
  logic [3:0]  data_length;
  logic [63:0] data_bytes;

  modport source (
    output valid, starts_packet, frames_in_packet, frame_identifier, is_extended,
           data_length, data_bytes,
    input  ready
  );
  modport sink (
    input  valid, starts_packet, frames_in_packet, frame_identifier, is_extended,
           data_length, data_bytes,
    output ready
  );
endinterface

// File: hdl/cfudp_byte_if.sv
// Handshake channel carrying one packet byte per item.
interface cfudp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_frame;

  modport source (output valid, out_byte, last_of_frame, input ready);
  modport sink (input valid, out_byte, last_of_frame, output ready);
endinterface

// File: hdl/cfudp_front.sv
// Front end: accepts frames, assigns sequence numbers, builds queue entries.
module cfudp_front import cfudp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  cfudp_frame_if.sink  frame,
  input  cfudp_qstat_t qstat,
  output logic         push,
  output cfudp_job_t   job
);

  logic [7:0] seq;

  // Take a frame whenever the queue has room
  assign frame.ready = !qstat.full;
  assign push        = frame.valid && frame.ready;

  // Advance the sequence number on every header
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= 8'd0;
    end else if (push && frame.starts_packet) begin
      seq <= seq + 8'd1;
    end
  end

  // Build the entry: identifier word, saturated length
  always_comb begin
    job.hdr     = frame.starts_packet;
    job.seq     = seq;
    job.count   = frame.frames_in_packet;
    job.id_word = {frame.is_extended, 2'b00, frame.frame_identifier};
    job.len     = (frame.data_length > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES)
                                                           : frame.data_length;
    job.data    = frame.data_bytes;
  end

endmodule

// File: hdl/cfudp_queue.sv
// Short frame queue between the front end and the byte serializer.
module cfudp_queue import cfudp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cfudp_job_t   job,
  input  logic         pop,
  output cfudp_job_t   head,
  output cfudp_qstat_t qstat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfudp_job_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  assign head        = entries[rd_ptr];
  assign qstat.full  = (cnt == CNT_W'(DEPTH));
  assign qstat.empty = (cnt == '0);

endmodule

// File: hdl/cfudp_back.sv
// Back end: walks each queued frame and emits its bytes through an output register.
module cfudp_back import cfudp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfudp_qstat_t  qstat,
  input  cfudp_job_t    head,
  output logic          pop,
  output logic          busy,
  cfudp_byte_if.source  stream
);

  // Byte positions within one frame's output
  localparam logic [4:0] POS_VERSION = 5'd0;
  localparam logic [4:0] POS_OPCODE  = 5'd1;
  localparam logic [4:0] POS_SEQ     = 5'd2;
  localparam logic [4:0] POS_CNT_HI  = 5'd3;
  localparam logic [4:0] POS_CNT_LO  = 5'd4;
  localparam logic [4:0] POS_ID3     = 5'd5;
  localparam logic [4:0] POS_ID2     = 5'd6;
  localparam logic [4:0] POS_ID1     = 5'd7;
  localparam logic [4:0] POS_ID0     = 5'd8;
  localparam logic [4:0] POS_LEN     = 5'd9;
  localparam logic [4:0] POS_DATA    = 5'd10;

  cfudp_job_t cur;
  logic [4:0] pos;
  logic       active;
  logic       ov;
  logic [7:0] ob;
  logic       ol;

  logic       advance;
  logic       emit;
  logic       last;
  logic       load;
  logic [4:0] end_pos;
  logic [4:0] doff;
  logic [7:0] byte_sel;

  // Step control: output register free, current frame done, next frame ready
  assign end_pos = POS_LEN + {1'b0, cur.len};
  assign advance = !ov || stream.ready;
  assign emit    = advance && active;
  assign last    = (pos == end_pos);
  assign load    = !qstat.empty && (!active || (emit && last));
  assign pop     = load;
  assign busy    = active;
  assign doff    = pos - POS_DATA;

  // Select the byte at the current position
  always_comb begin
    unique case (pos)
      POS_VERSION: byte_sel = FORMAT_VERSION;
      POS_OPCODE:  byte_sel = OPCODE_DATA;
      POS_SEQ:     byte_sel = cur.seq;
      POS_CNT_HI:  byte_sel = cur.count[15:8];
      POS_CNT_LO:  byte_sel = cur.count[7:0];
      POS_ID3:     byte_sel = cur.id_word[31:24];
      POS_ID2:     byte_sel = cur.id_word[23:16];
      POS_ID1:     byte_sel = cur.id_word[15:8];
      POS_ID0:     byte_sel = cur.id_word[7:0];
      POS_LEN:     byte_sel = {4'd0, cur.len};
      default:     byte_sel = cur.data[{doff[2:0], 3'b000} +: 8];
    endcase
  end

  // Advance through the frame, load the next one on its last byte or when idle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ov     <= 1'b0;
    end else begin
      if (advance) begin
        ov <= active;
      end
      if (emit) begin
        ob <= byte_sel;
        ol <= last;
      end
      if (load) begin
        cur    <= head;
        pos    <= head.hdr ? POS_VERSION : POS_ID3;
        active <= 1'b1;
      end else begin
        if (emit) begin
          pos <= pos + 5'd1;
        end
        if (emit && last) begin
          active <= 1'b0;
        end
      end
    end
  end

  assign stream.valid         = ov;
  assign stream.out_byte      = ob;
  assign stream.last_of_frame = ol;

endmodule

// File: hdl/can_frame_to_udp_packet_framer.sv
// Top level of the CAN frame to packet byte framer.
//
//   channel  dir  payload                                          per item
//   frame    in   starts_packet, frames_in_packet, identifier ...  one CAN frame
//   stream   out  out_byte, last_of_frame                          one packet byte
//
// A frame yields 5 to 18 bytes: 5 header bytes when it starts a packet, then
// 4 identifier bytes, a length byte and up to 8 data bytes, one byte per cycle
// through the single output register while the stream is ready.
// Reset clears the sequence number to 0 and empties the queue; no clearing pass.
// Up to QUEUE_DEPTH frames wait between front end and serializer, so frames are
// taken while bytes are stalled downstream.
`include "can_frame_to_udp_packet_framer_defines.svh"
module can_frame_to_udp_packet_framer import cfudp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  cfudp_frame_if.sink  frame,
  cfudp_byte_if.source stream
);

  cfudp_qstat_t qstat;
  cfudp_job_t   job;
  cfudp_job_t   head;
  logic         push;
  logic         pop;
  logic         busy;

  // Classify incoming frames
  cfudp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .qstat (qstat),
    .push  (push),
    .job   (job)
  );

  // Hold frames between the two ends
  cfudp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .job   (job),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Serialize frames into bytes
  cfudp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop),
    .busy   (busy),
    .stream (stream)
  );

  // Checks
  `CFUDP_ASSERT_IMP(a_no_push_when_full, clk, rst, push, !qstat.full)
  `CFUDP_ASSERT_IMP(a_no_pop_when_empty, clk, rst, pop, !qstat.empty)
  `CFUDP_ASSERT_NXT(a_item_held, clk, rst, frame.valid && frame.ready, !qstat.empty || busy)

endmodule
